@@ design/rcp_pkg.sv @@
// package: types, codes and constants of the rectangle clip stream
`timescale 1ns / 1ps
package rcp_pkg;

  localparam int CoordBits = 32;
  localparam int WideBits  = CoordBits + 2;
  localparam int ProdBits  = 2 * (CoordBits + 1);
  localparam int CntBits   = $clog2(ProdBits + 1);
  localparam int NumRegs   = 4;
  localparam int IdxBits   = 2;
  localparam logic [WideBits-1:0] QLim = WideBits'(1) << (CoordBits + 1);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [WideBits-1:0]  wide_t;

  typedef enum logic [1:0] {
    OP_POINT = 2'd0, OP_VECTOR = 2'd1, OP_CONT = 2'd2, OP_BAD = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0, KIND_VECTOR = 2'd1, KIND_CONT = 2'd2, KIND_ERR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_SINGLE = 2'd1, ERR_NO_BETWEEN = 2'd2, ERR_BAD_OP = 2'd3
  } err_e;

  localparam logic [IdxBits-1:0] REG_LEFT   = 2'd0;
  localparam logic [IdxBits-1:0] REG_BOTTOM = 2'd1;
  localparam logic [IdxBits-1:0] REG_RIGHT  = 2'd2;
  localparam logic [IdxBits-1:0] REG_TOP    = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  bright;
    coord_t      ax;
    coord_t      ay;
    coord_t      az;
    coord_t      bx;
    coord_t      by;
    coord_t      bz;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  err_code;
    logic [7:0]  out_bright;
    coord_t      px;
    coord_t      py;
    coord_t      pz;
    coord_t      qx;
    coord_t      qy;
    coord_t      qz;
  } out_word_t;

  // classified job passed from front to back
  typedef struct packed {
    logic        clip;    // needs edge intersections
    logic        cont;    // continuation with start inside
    logic        p1in;
    out_word_t   res;     // direct result when not clip
    logic [7:0]  bright;
    coord_t      x1;
    coord_t      y1;
    coord_t      z1;
    coord_t      x2;
    coord_t      y2;
    coord_t      z2;
  } job_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } win_t;

endpackage

@@ design/rcp_stream_if.sv @@
// valid/ready stream interface
`timescale 1ns / 1ps
interface rcp_stream_if #(parameter int Width = 8) (input logic clk_i);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/rcp_front.sv @@
// front end: window test, state update and command classification
`timescale 1ns / 1ps
module rcp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rcp_pkg::win_t   win_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rcp_pkg::in_word_t in_data_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output rcp_pkg::job_t   job_o
);
  import rcp_pkg::*;

  coord_t     prev_x_q, prev_y_q, prev_z_q;
  logic [7:0] prev_br_q;
  logic       acc;
  job_t       j;
  logic       in1, in2, outside;
  coord_t     x1, y1, z1;
  logic [7:0] br;

  function automatic logic inwin(coord_t x, coord_t y, win_t w);
    return !(x < w.left || x > w.right || y < w.bottom || y > w.top);
  endfunction

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign acc         = in_valid_i && job_ready_i;

  // classify one command
  always_comb begin
    if (in_data_i.opcode == OP_CONT) begin
      x1 = prev_x_q; y1 = prev_y_q; z1 = prev_z_q; br = prev_br_q;
    end else begin
      x1 = in_data_i.ax; y1 = in_data_i.ay; z1 = in_data_i.az; br = in_data_i.bright;
    end
    in1 = inwin(x1, y1, win_i);
    in2 = inwin(in_data_i.bx, in_data_i.by, win_i);
    outside = (y1 > win_i.top && in_data_i.by > win_i.top) ||
              (y1 < win_i.bottom && in_data_i.by < win_i.bottom) ||
              (x1 > win_i.right && in_data_i.bx > win_i.right) ||
              (x1 < win_i.left && in_data_i.bx < win_i.left);
    j        = '0;
    j.bright = br;
    j.x1 = x1; j.y1 = y1; j.z1 = z1;
    j.x2 = in_data_i.bx; j.y2 = in_data_i.by; j.z2 = in_data_i.bz;
    j.p1in = in1;
    j.res.kind = KIND_ERR;
    unique case (opcode_e'(in_data_i.opcode))
      OP_BAD: begin
        j.res.kind = KIND_ERR; j.res.err_code = ERR_BAD_OP;
      end
      OP_POINT: begin
        if (in1) begin
          j.res.kind = KIND_POINT; j.res.out_bright = br;
          j.res.px = x1; j.res.py = y1; j.res.pz = z1;
        end else begin
          j.res.kind = KIND_ERR; j.res.err_code = ERR_NONE;  // dropped
        end
      end
      OP_VECTOR: begin
        if (in1 && in2) begin
          j.res.kind = KIND_VECTOR; j.res.out_bright = br;
          j.res.px = x1; j.res.py = y1; j.res.pz = z1;
          j.res.qx = j.x2; j.res.qy = j.y2; j.res.qz = j.z2;
        end else if (!outside) begin
          j.clip = 1'b1;
        end else begin
          j.res.err_code = ERR_NONE;
        end
      end
      default: begin
        if (in1 && in2) begin
          j.res.kind = KIND_CONT; j.res.out_bright = br;
          j.res.qx = j.x2; j.res.qy = j.y2; j.res.qz = j.z2;
        end else if (in1) begin
          j.clip = 1'b1; j.cont = 1'b1;
        end else if (!outside) begin
          j.clip = 1'b1;
        end else begin
          j.res.err_code = ERR_NONE;
        end
      end
    endcase
  end

  assign job_o = j;

  // last end point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0; prev_y_q <= '0; prev_z_q <= '0; prev_br_q <= '0;
    end else if (acc) begin
      unique case (opcode_e'(in_data_i.opcode))
        OP_POINT: begin
          prev_x_q <= in_data_i.ax; prev_y_q <= in_data_i.ay;
          prev_z_q <= in_data_i.az; prev_br_q <= in_data_i.bright;
        end
        OP_VECTOR: begin
          prev_x_q <= in_data_i.bx; prev_y_q <= in_data_i.by;
          prev_z_q <= in_data_i.bz; prev_br_q <= in_data_i.bright;
        end
        OP_CONT: begin
          prev_x_q <= in_data_i.bx; prev_y_q <= in_data_i.by;
          prev_z_q <= in_data_i.bz;
        end
        default: begin
        end
      endcase
    end
  end
endmodule

@@ design/rcp_queue.sv @@
// two-entry queue of classified jobs
`timescale 1ns / 1ps
module rcp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  rcp_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output rcp_pkg::job_t rd_data_o
);
  import rcp_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

@@ design/rcp_divider.sv @@
// restoring divider: base + trunc(e * n / d), quotient saturated
`timescale 1ns / 1ps
module rcp_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  rcp_pkg::wide_t        base_i,
  input  rcp_pkg::wide_t        e_i,
  input  rcp_pkg::wide_t        n_i,
  input  rcp_pkg::wide_t        d_i,
  output logic                  done_o,
  output rcp_pkg::wide_t        res_o
);
  import rcp_pkg::*;

  localparam int MagBits = CoordBits + 1;

  // phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]          ph_q;
  logic [MagBits-1:0]  a_q, b_q, dv_q;
  logic                neg_q;
  wide_t               base_q;
  logic [ProdBits-1:0] num_q;
  logic [MagBits:0]    rem_q;
  logic [WideBits-1:0] quo_q;
  logic [CntBits-1:0]  cnt_q;
  logic [MagBits:0]    rem_sh, rem_sub;
  logic [WideBits:0]   quo_sh;
  logic [WideBits-1:0] quo_n;

  function automatic logic [MagBits-1:0] mag(wide_t v);
    wide_t t;
    t = v[WideBits-1] ? -v : v;
    return t[MagBits-1:0];
  endfunction

  // one quotient bit per cycle, shifted one bit wider so a saturated value stays saturated
  always_comb begin
    rem_sh  = {rem_q[MagBits-1:0], num_q[ProdBits-1]};
    rem_sub = rem_sh - {1'b0, dv_q};
    quo_sh  = {quo_q, rem_sh >= {1'b0, dv_q}};
    if (quo_sh > {1'b0, QLim}) quo_n = QLim;
    else quo_n = quo_sh[WideBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; cnt_q <= '0;
    end else begin
      unique case (ph_q)
        PH_IDLE: if (start_i) ph_q <= PH_MUL;
        PH_MUL: begin
          ph_q <= PH_DIV; cnt_q <= CntBits'(ProdBits);
        end
        PH_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntBits'(1)) ph_q <= PH_DONE;
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ph_q)
      PH_IDLE: begin
        a_q <= mag(e_i); b_q <= mag(n_i); dv_q <= mag(d_i);
        neg_q <= e_i[WideBits-1] ^ n_i[WideBits-1] ^ d_i[WideBits-1];
        base_q <= base_i;
      end
      PH_MUL: begin
        num_q <= a_q * b_q;
        rem_q <= '0; quo_q <= '0;
      end
      PH_DIV: begin
        num_q <= {num_q[ProdBits-2:0], 1'b0};
        rem_q <= (rem_sh >= {1'b0, dv_q}) ? rem_sub : rem_sh;
        quo_q <= quo_n;
      end
      default: begin
      end
    endcase
  end

  assign done_o = ph_q == PH_DONE;
  assign res_o  = neg_q ? base_q - wide_t'(quo_q) : base_q + wide_t'(quo_q);
endmodule

@@ design/rcp_back.sv @@
// back end: edge intersections on the shared divider and result assembly
`timescale 1ns / 1ps
module rcp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rcp_pkg::win_t   win_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  rcp_pkg::job_t   job_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rcp_pkg::out_word_t out_data_o
);
  import rcp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] st_q;
  job_t       job_q;
  logic [1:0] edge_q;
  logic [1:0] n_q;
  coord_t     sx_q [2];
  coord_t     sy_q [2];
  out_word_t  res_q;
  logic       ov_q;
  wide_t      dbase, de, dn, dd, dres;
  logic       dstart, ddone, hit, dx_nz;
  wide_t      x1w, y1w, x2w, y2w;
  coord_t     hx, hy;
  logic [1:0] b0, b1;
  out_word_t  fin;
  logic       load;
  out_word_t  load_word;

  assign x1w = wide_t'(job_q.x1);
  assign y1w = wide_t'(job_q.y1);
  assign x2w = wide_t'(job_q.x2);
  assign y2w = wide_t'(job_q.y2);
  assign dx_nz = job_q.x2 != job_q.x1;

  // operands of the current edge: bottom, top, left, right
  always_comb begin
    if (!edge_q[1]) begin
      dbase = x1w; dn = x2w - x1w; dd = y2w - y1w;
      de = (edge_q[0] ? wide_t'(win_i.top) : wide_t'(win_i.bottom)) - y1w;
    end else begin
      dbase = y1w; dn = y2w - y1w; dd = x2w - x1w;
      de = (edge_q[0] ? wide_t'(win_i.right) : wide_t'(win_i.left)) - x1w;
    end
  end

  assign dstart = st_q == ST_START;

  rcp_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .base_i(dbase), .e_i(de), .n_i(dn), .d_i(dd),
    .done_o(ddone), .res_o(dres)
  );

  assign hit = !edge_q[1]
             ? (dres >= wide_t'(win_i.left) && dres <= wide_t'(win_i.right))
             : (dres >= wide_t'(win_i.bottom) && dres <= wide_t'(win_i.top));
  assign hx = edge_q[1] ? (edge_q[0] ? win_i.right : win_i.left) : coord_t'(dres);
  assign hy = edge_q[1] ? coord_t'(dres) : (edge_q[0] ? win_i.top : win_i.bottom);

  function automatic logic btw(coord_t a, coord_t b, coord_t c);
    return (a <= b && b <= c) || (a >= b && b >= c);
  endfunction

  // final result from the hits
  always_comb begin
    fin = '0;
    b0 = {1'b0, btw(job_q.x1, sx_q[0], job_q.x2) && btw(job_q.y1, sy_q[0], job_q.y2)};
    b1 = {1'b0, btw(job_q.x1, sx_q[1], job_q.x2) && btw(job_q.y1, sy_q[1], job_q.y2)};
    if (n_q == 2'd0) begin
      fin.kind = KIND_ERR; fin.err_code = ERR_NONE;
    end else if (n_q == 2'd1) begin
      fin.kind = KIND_ERR; fin.err_code = ERR_SINGLE;
    end else if (b0 + b1 == 2'd0) begin
      fin.kind = KIND_ERR; fin.err_code = ERR_NO_BETWEEN;
    end else begin
      fin.out_bright = job_q.bright;
      if (b0 + b1 == 2'd2) begin
        fin.kind = KIND_VECTOR;
        fin.px = sx_q[0]; fin.py = sy_q[0]; fin.pz = job_q.z1;
        fin.qx = sx_q[1]; fin.qy = sy_q[1]; fin.qz = job_q.z2;
      end else if (job_q.p1in) begin
        fin.kind = job_q.cont ? KIND_CONT : KIND_VECTOR;
        if (!job_q.cont) begin
          fin.px = job_q.x1; fin.py = job_q.y1; fin.pz = job_q.z1;
        end
        fin.qx = b1[0] ? sx_q[1] : sx_q[0]; fin.qy = b1[0] ? sy_q[1] : sy_q[0];
        fin.qz = job_q.z2;
      end else begin
        fin.kind = KIND_VECTOR;
        fin.px = b1[0] ? sx_q[1] : sx_q[0]; fin.py = b1[0] ? sy_q[1] : sy_q[0];
        fin.pz = job_q.z1;
        fin.qx = job_q.x2; fin.qy = job_q.y2; fin.qz = job_q.z2;
      end
    end
  end

  assign job_ready_o = st_q == ST_IDLE && (!ov_q || out_ready_i);

  // result register load: direct result on accept or clipped result at the end, except for dropped jobs
  always_comb begin
    load      = 1'b0;
    load_word = job_i.res;
    if (st_q == ST_IDLE) begin
      if (job_valid_i && job_ready_o && !job_i.clip &&
          !(job_i.res.kind == KIND_ERR && job_i.res.err_code == ERR_NONE)) begin
        load = 1'b1;
      end
    end else if (st_q == ST_OUT) begin
      if ((!ov_q || out_ready_i) && !(fin.kind == KIND_ERR && fin.err_code == ERR_NONE)) begin
        load = 1'b1; load_word = fin;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= load_word;
  end

  // sequencer over the window sides in order bottom, top, left, right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; edge_q <= '0; n_q <= '0;
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (job_valid_i && job_ready_o) begin
            job_q <= job_i; n_q <= '0;
            if (job_i.clip) begin
              st_q <= ST_START;
              if (job_i.y2 != job_i.y1) edge_q <= 2'd0;
              else if (job_i.x2 != job_i.x1) edge_q <= 2'd2;
              else st_q <= ST_FIN;
            end
          end
        end
        ST_START: st_q <= ST_WAIT;
        ST_WAIT: begin
          if (ddone) begin
            if (hit) begin
              sx_q[n_q[0]] <= hx; sy_q[n_q[0]] <= hy; n_q <= n_q + 2'd1;
            end
            if (edge_q == 2'd0) begin
              edge_q <= 2'd1; st_q <= ST_START;
            end else if (edge_q == 2'd1) begin
              if ((n_q + {1'b0, hit}) < 2'd2 && dx_nz) begin
                edge_q <= 2'd2; st_q <= ST_START;
              end else st_q <= ST_FIN;
            end else if (edge_q == 2'd2 && (n_q + {1'b0, hit}) < 2'd2) begin
              edge_q <= 2'd3; st_q <= ST_START;
            end else st_q <= ST_FIN;
          end
        end
        ST_FIN: st_q <= ST_OUT;
        default: begin
          if (!ov_q || out_ready_i) begin
            st_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;
endmodule

@@ design/rect_clip_plot_stream.sv @@
// top level: rectangle clip of a plot command stream
// no edge intersection needed: one word per cycle unless a clip or the output stalls
// clipped vectors: one divide per window side, up to all four sides
// throughput is set by the single shared bit-serial divider in the back end
// reset: asynchronous active low; window 0,0,max,max, stored end point zero
`timescale 1ns / 1ps
module rect_clip_plot_stream (
  input  logic clk_i,
  input  logic rst_ni,
  rcp_stream_if.sink   in_s,
  rcp_stream_if.source out_s,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import rcp_pkg::*;

  win_t      win_q;
  logic      fv, fr, qv, qr;
  job_t      fj, qj;
  out_word_t od;

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.left <= '0; win_q.bottom <= '0;
      win_q.right <= {1'b0, {(CoordBits-1){1'b1}}};
      win_q.top <= {1'b0, {(CoordBits-1){1'b1}}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEFT:   win_q.left <= cfg_data_i;
        REG_BOTTOM: win_q.bottom <= cfg_data_i;
        REG_RIGHT:  win_q.right <= cfg_data_i;
        default:    win_q.top <= cfg_data_i;
      endcase
    end
  end

  rcp_front u_front (
    .clk_i, .rst_ni, .win_i(win_q), .in_valid_i(in_s.valid), .in_ready_o(in_s.ready),
    .in_data_i(in_word_t'(in_s.data)), .job_valid_o(fv), .job_ready_i(fr), .job_o(fj)
  );

  rcp_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fj),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qj)
  );

  rcp_back u_back (
    .clk_i, .rst_ni, .win_i(win_q), .job_valid_i(qv), .job_ready_o(qr), .job_i(qj),
    .out_valid_o(out_s.valid), .out_ready_i(out_s.ready), .out_data_o(od)
  );

  assign out_s.data = od;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && !out_s.ready |=> out_s.valid && $stable(out_s.data))
    else $error("result dropped under stall");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_s.valid && in_s.ready |-> !cfg_we_i)
    else $error("window written while busy");
`endif
endmodule
